// ----- rtl/core/ille_pkg.sv -----
`timescale 1ns / 1ps
// ille_pkg: shared sizes, request modes and status codes for the linked list engine
// depends on nothing; imported by indexed_linked_list_engine and its bench

package ille_pkg;

   // node storage
   localparam int CAPACITY   = 1024;
   localparam int SLOT_BITS  = $clog2(CAPACITY);
   localparam int COUNT_BITS = $clog2(CAPACITY + 1);
   localparam int VALUE_BITS = 32;

   // fixed port widths
   localparam int MODE_BITS     = 3;
   localparam int POS_BITS      = 16;
   localparam int ITEM_BITS     = 32;
   localparam int STATUS_BITS   = 2;
   localparam int LENGTH_BITS   = 11;

   // width for comparing a position against the element count
   localparam int CMP_BITS = ((POS_BITS > COUNT_BITS) ? POS_BITS : COUNT_BITS) + 1;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_READ   = 3'd0,
      MODE_HEAD   = 3'd1,
      MODE_TAIL   = 3'd2,
      MODE_BEFORE = 3'd3,
      MODE_DELETE = 3'd4
   } mode_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_DONE    = 2'd0,
      STATUS_BAD_POS = 2'd1,
      STATUS_FULL    = 2'd2
   } status_type;

   // where a new node lands relative to the existing chain
   typedef enum logic [1:0] {
      KIND_EMPTY = 2'd0,
      KIND_HEAD  = 2'd1,
      KIND_TAIL  = 2'd2,
      KIND_MID   = 2'd3
   } kind_type;

endpackage

// ----- rtl/core/indexed_linked_list_engine.sv -----
`timescale 1ns / 1ps
// indexed_linked_list_engine: bounded singly linked list with a free list, node memories inside
// depends on ille_pkg

// A request is taken when start is high and busy is low; exactly one response
// follows, shown on the rsp_ ports for one cycle while rsp_strobe is high, and
// the receiver cannot hold it off. The list lives in two node memories (value
// and link), each with a registered read. Refused requests answer in the cycle
// after they are presented. Head and tail inserts need no walk, and pop the free
// list first when the slot comes from it. A read walks the chain to its node,
// a delete to the node before (at position 0 it unlinks the head directly), an
// insert before a position in the middle to the node before it: the walk down
// the chain follows one link per cycle through the single link memory read
// port, so its length grows with the position. busy drops in the cycle the
// response is shown, so the next request may enter then. No clearing pass is
// needed after reset: only the tail's link is used unwritten, and never followed.

module indexed_linked_list_engine
   import ille_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [MODE_BITS-1:0]          req_mode,
   input  logic [POS_BITS-1:0]           req_position,
   input  logic signed [ITEM_BITS-1:0]   req_item_value,
   output logic                          rsp_strobe,
   output logic [STATUS_BITS-1:0]        rsp_status,
   output logic signed [ITEM_BITS-1:0]   rsp_read_value,
   output logic [LENGTH_BITS-1:0]        rsp_list_length
);

   // sequencer states, one-hot
   typedef enum logic [11:0] {
      S_IDLE  = 12'b0000_0000_0001,  // wait for a request
      S_TAKE  = 12'b0000_0000_0010,  // pop the free list
      S_PLACE = 12'b0000_0000_0100,  // hook a new node in, or start the walk
      S_WALK  = 12'b0000_0000_1000,  // follow one link per cycle
      S_AT    = 12'b0000_0001_0000,  // target slot known, read it
      S_RVAL  = 12'b0000_0010_0000,  // value read data back
      S_IMID  = 12'b0000_0100_0000,  // new node takes prev's link
      S_ILINK = 12'b0000_1000_0000,  // prev points at the new node
      S_DHEAD = 12'b0001_0000_0000,  // unlink the head node
      S_DV    = 12'b0010_0000_0000,  // victim slot known, read its link
      S_DN    = 12'b0100_0000_0000,  // prev skips the victim
      S_DF    = 12'b1000_0000_0000   // victim onto the free list
   } state_type;

   // node memories
   logic [VALUE_BITS-1:0] value_mem [CAPACITY];
   logic [SLOT_BITS-1:0]  link_mem  [CAPACITY];

   // control state
   state_type              state_ff, state_in;
   logic [SLOT_BITS-1:0]   head_ff, head_in;
   logic [SLOT_BITS-1:0]   tail_ff, tail_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [SLOT_BITS-1:0]   free_head_ff, free_head_in;
   logic [COUNT_BITS-1:0]  free_count_ff, free_count_in;
   logic [COUNT_BITS-1:0]  fresh_ff, fresh_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;

   // per-request working registers
   mode_type               op_ff, op_in;
   kind_type               kind_ff, kind_in;
   logic [SLOT_BITS-1:0]   pos_ff, pos_in;
   logic [SLOT_BITS-1:0]   slot_ff, slot_in;     // new node on insert, victim on delete
   logic [SLOT_BITS-1:0]   tgt_ff, tgt_in;       // walk result
   logic [SLOT_BITS-1:0]   steps_ff, steps_in;
   logic                   last_ff, last_in;     // delete removes the tail

   // response payload
   logic [STATUS_BITS-1:0]        rsp_status_ff, rsp_status_in;
   logic signed [ITEM_BITS-1:0]   rsp_read_value_ff, rsp_read_value_in;
   logic [LENGTH_BITS-1:0]        rsp_list_length_ff, rsp_list_length_in;

   // memory ports
   logic                   link_we;
   logic [SLOT_BITS-1:0]   link_waddr, link_wdata, link_raddr;
   logic [SLOT_BITS-1:0]   link_rd_ff;
   logic                   value_we;
   logic [SLOT_BITS-1:0]   value_waddr, value_raddr;
   logic [VALUE_BITS-1:0]  value_wdata;
   logic [VALUE_BITS-1:0]  value_rd_ff;

   // request decode helpers
   logic [CMP_BITS-1:0]    pos_wide, cnt_wide;
   logic                   list_full;
   logic                   walk_go;
   logic [SLOT_BITS-1:0]   walk_k;
   logic                   done_go;
   logic                   reject_go;
   status_type             reject_code;
   logic                   release_go;
   logic signed [ITEM_BITS-1:0] read_ext;

   assign pos_wide  = CMP_BITS'(req_position);
   assign cnt_wide  = CMP_BITS'(count_ff);
   assign list_full = (count_ff == COUNT_BITS'(CAPACITY));
   assign read_ext  = ITEM_BITS'($signed(value_rd_ff));

   always_comb begin
      state_in           = state_ff;
      head_in            = head_ff;
      tail_in            = tail_ff;
      count_in           = count_ff;
      free_head_in       = free_head_ff;
      free_count_in      = free_count_ff;
      fresh_in           = fresh_ff;
      op_in              = op_ff;
      kind_in            = kind_ff;
      pos_in             = pos_ff;
      slot_in            = slot_ff;
      tgt_in             = tgt_ff;
      steps_in           = steps_ff;
      last_in            = last_ff;
      rsp_strobe_in      = 1'b0;
      rsp_status_in      = rsp_status_ff;
      rsp_read_value_in  = rsp_read_value_ff;
      rsp_list_length_in = rsp_list_length_ff;

      link_we     = 1'b0;
      link_waddr  = slot_ff;
      link_wdata  = free_head_ff;
      link_raddr  = free_head_ff;
      value_we    = 1'b0;
      value_waddr = slot_ff;
      value_wdata = req_item_value[VALUE_BITS-1:0];
      value_raddr = tgt_ff;

      walk_go     = 1'b0;
      walk_k      = '0;
      done_go     = 1'b0;
      reject_go   = 1'b0;
      reject_code = STATUS_BAD_POS;
      release_go  = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in  = mode_type'(req_mode);
               pos_in = req_position[SLOT_BITS-1:0];
               case (req_mode)
                  MODE_READ: begin
                     if (pos_wide >= cnt_wide) begin
                        reject_go = 1'b1;
                     end else begin
                        walk_go = 1'b1;
                        walk_k  = req_position[SLOT_BITS-1:0];
                     end
                  end
                  MODE_HEAD, MODE_TAIL, MODE_BEFORE: begin
                     if (req_mode == MODE_BEFORE && pos_wide > cnt_wide) begin
                        reject_go = 1'b1;
                     end else if (list_full) begin
                        reject_go   = 1'b1;
                        reject_code = STATUS_FULL;
                     end else begin
                        // new slot: recycled first, else the next never-used one
                        if (free_count_ff != '0) begin
                           slot_in    = free_head_ff;
                           link_raddr = free_head_ff;
                           state_in   = S_TAKE;
                        end else begin
                           slot_in  = fresh_ff[SLOT_BITS-1:0];
                           fresh_in = fresh_ff + COUNT_BITS'(1);
                           state_in = S_PLACE;
                        end
                        value_we    = 1'b1;
                        value_waddr = slot_in;
                        // a tail insert ignores the position field
                        if (count_ff == '0) begin
                           kind_in = KIND_EMPTY;
                        end else if (req_mode == MODE_HEAD ||
                                     (req_mode == MODE_BEFORE && pos_wide == '0)) begin
                           kind_in = KIND_HEAD;
                        end else if (req_mode == MODE_TAIL || pos_wide == cnt_wide) begin
                           kind_in = KIND_TAIL;
                        end else begin
                           kind_in = KIND_MID;
                        end
                     end
                  end
                  MODE_DELETE: begin
                     if (pos_wide >= cnt_wide) begin
                        reject_go = 1'b1;
                     end else if (pos_wide == '0) begin
                        slot_in    = head_ff;
                        link_raddr = head_ff;
                        state_in   = S_DHEAD;
                     end else begin
                        walk_go = 1'b1;
                        walk_k  = req_position[SLOT_BITS-1:0] - SLOT_BITS'(1);
                        last_in = ((pos_wide + CMP_BITS'(1)) == cnt_wide);
                     end
                  end
                  default: begin
                     reject_go = 1'b1;
                  end
               endcase
            end
         end

         S_TAKE: begin
            free_head_in  = link_rd_ff;
            free_count_in = free_count_ff - COUNT_BITS'(1);
            state_in      = S_PLACE;
         end

         S_PLACE: begin
            case (kind_ff)
               KIND_EMPTY: begin
                  head_in  = slot_ff;
                  tail_in  = slot_ff;
                  count_in = count_ff + COUNT_BITS'(1);
                  done_go  = 1'b1;
               end
               KIND_HEAD: begin
                  link_we    = 1'b1;
                  link_waddr = slot_ff;
                  link_wdata = head_ff;
                  head_in    = slot_ff;
                  count_in   = count_ff + COUNT_BITS'(1);
                  done_go    = 1'b1;
               end
               KIND_TAIL: begin
                  link_we    = 1'b1;
                  link_waddr = tail_ff;
                  link_wdata = slot_ff;
                  tail_in    = slot_ff;
                  count_in   = count_ff + COUNT_BITS'(1);
                  done_go    = 1'b1;
               end
               default: begin
                  // middle insert: find the node before the position
                  walk_go = 1'b1;
                  walk_k  = pos_ff - SLOT_BITS'(1);
               end
            endcase
         end

         S_WALK: begin
            if (steps_ff == SLOT_BITS'(1)) begin
               tgt_in   = link_rd_ff;
               state_in = S_AT;
            end else begin
               link_raddr = link_rd_ff;
               steps_in   = steps_ff - SLOT_BITS'(1);
            end
         end

         S_AT: begin
            link_raddr  = tgt_ff;
            value_raddr = tgt_ff;
            case (op_ff)
               MODE_READ:   state_in = S_RVAL;
               MODE_DELETE: state_in = S_DV;
               default:     state_in = S_IMID;
            endcase
         end

         S_RVAL: begin
            done_go = 1'b1;
         end

         S_IMID: begin
            link_we    = 1'b1;
            link_waddr = slot_ff;
            link_wdata = link_rd_ff;
            state_in   = S_ILINK;
         end

         S_ILINK: begin
            link_we    = 1'b1;
            link_waddr = tgt_ff;
            link_wdata = slot_ff;
            count_in   = count_ff + COUNT_BITS'(1);
            done_go    = 1'b1;
         end

         S_DHEAD: begin
            head_in    = link_rd_ff;
            release_go = 1'b1;
         end

         S_DV: begin
            slot_in    = link_rd_ff;
            link_raddr = link_rd_ff;
            state_in   = S_DN;
         end

         S_DN: begin
            link_we    = 1'b1;
            link_waddr = tgt_ff;
            link_wdata = link_rd_ff;
            if (last_ff) begin
               tail_in = tgt_ff;
            end
            state_in = S_DF;
         end

         S_DF: begin
            release_go = 1'b1;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // start a walk: position zero lands on the head at once
      if (walk_go) begin
         if (walk_k == '0) begin
            tgt_in   = head_ff;
            state_in = S_AT;
         end else begin
            link_raddr = head_ff;
            steps_in   = walk_k;
            state_in   = S_WALK;
         end
      end

      // push the victim slot onto the free list
      if (release_go) begin
         link_we       = 1'b1;
         link_waddr    = slot_ff;
         link_wdata    = free_head_ff;
         free_head_in  = slot_ff;
         free_count_in = free_count_ff + COUNT_BITS'(1);
         count_in      = count_ff - COUNT_BITS'(1);
         done_go       = 1'b1;
      end

      if (done_go) begin
         rsp_strobe_in      = 1'b1;
         rsp_status_in      = STATUS_DONE;
         rsp_read_value_in  = (op_ff == MODE_READ) ? read_ext : '0;
         rsp_list_length_in = LENGTH_BITS'(count_in);
         state_in           = S_IDLE;
      end

      if (reject_go) begin
         rsp_strobe_in      = 1'b1;
         rsp_status_in      = reject_code;
         rsp_read_value_in  = '0;
         rsp_list_length_in = LENGTH_BITS'(count_ff);
      end
   end

   // node memories, one write and one registered read each
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      link_rd_ff <= link_mem[link_raddr];
   end

   always_ff @(posedge clock) begin
      if (value_we) begin
         value_mem[value_waddr] <= value_wdata;
      end
      value_rd_ff <= value_mem[value_raddr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         free_head_ff  <= '0;
         free_count_ff <= '0;
         fresh_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         free_head_ff  <= free_head_in;
         free_count_ff <= free_count_in;
         fresh_ff      <= fresh_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff              <= op_in;
      kind_ff            <= kind_in;
      pos_ff             <= pos_in;
      slot_ff            <= slot_in;
      tgt_ff             <= tgt_in;
      steps_ff           <= steps_in;
      last_ff            <= last_in;
      rsp_status_ff      <= rsp_status_in;
      rsp_read_value_ff  <= rsp_read_value_in;
      rsp_list_length_ff <= rsp_list_length_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_list_length = rsp_list_length_ff;

`ifndef SYNTHESIS
   // the element count never passes the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(CAPACITY))
      else $error("element count beyond capacity");

   // every slot ever handed out is either in the list or on the free list, checked at idle
   a_slot_balance: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |->
         ((COUNT_BITS + 1)'(count_ff) + (COUNT_BITS + 1)'(free_count_ff)
          == (COUNT_BITS + 1)'(fresh_ff)))
      else $error("slot accounting out of balance");

   // a response only appears once the sequencer is back at rest
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response while busy");

   // the sequencer only leaves idle on a taken request
   a_busy_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy without a request");
`endif

endmodule

// ----- bench/indexed_linked_list_engine_tb.sv -----
`timescale 1ns / 1ps
// indexed_linked_list_engine_tb: self-checking bench for the linked list engine, random traffic
// plus directed edge cases; keeps its own copy of the list to predict every response
// depends on ille_pkg and indexed_linked_list_engine

module indexed_linked_list_engine_tb;
   import ille_pkg::*;

   // modes the block does not define, answered as a bad position
   localparam logic [MODE_BITS-1:0] MODE_UNUSED_FIRST = 3'd5;
   localparam logic [MODE_BITS-1:0] MODE_UNUSED_LAST  = 3'd7;

   localparam int IDLE_PERCENT  = 17;
   localparam int RESET_CYCLES  = 11;
   localparam int SETTLE_CYCLES = 64;
   localparam int REPORT_LIMIT  = 100;
   localparam int CYCLE_LIMIT   = 4000000;
   localparam int RANDOM_COUNT  = 320;
   localparam int LONG_LENGTH   = 240;

   typedef struct packed {
      status_type                  status;
      logic signed [ITEM_BITS-1:0] read_value;
      logic [LENGTH_BITS-1:0]      length;
   } list_answer_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic [MODE_BITS-1:0]        req_mode = '0;
   logic [POS_BITS-1:0]         req_position = '0;
   logic signed [ITEM_BITS-1:0] req_item_value = '0;
   logic                        rsp_strobe;
   logic [STATUS_BITS-1:0]      rsp_status;
   logic signed [ITEM_BITS-1:0] rsp_read_value;
   logic [LENGTH_BITS-1:0]      rsp_list_length;

   // responses owed by the block, oldest first
   list_answer_type answers_due[$];
   int unsigned  error_count = 0;
   int unsigned  cycle_count = 0;
   bit           steady_sender = 1'b0;

   // shadow copy of the list: node memories, chain ends and slot bookkeeping
   bit [VALUE_BITS-1:0] node_value [CAPACITY];
   bit [SLOT_BITS-1:0]  node_link  [CAPACITY];
   bit [SLOT_BITS-1:0]  head_at, tail_at, spare_head;
   bit [COUNT_BITS-1:0] length_now, spare_count, fresh_next;

   indexed_linked_list_engine DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_position    (req_position),
      .req_item_value  (req_item_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_read_value  (rsp_read_value),
      .rsp_list_length (rsp_list_length)
   );

   always #6 clock = ~clock;

   // run guard: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("indexed_linked_list_engine regression: fail");
         $finish;
      end
   end

   task automatic report_error(input string msg);
      if (error_count < REPORT_LIMIT)
         $display("error at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // follow the chain from the head, one link per step
   function automatic bit [SLOT_BITS-1:0] slot_of(input int unsigned steps);
      bit [SLOT_BITS-1:0] s;
      s = head_at;
      for (int unsigned k = 0; k < steps; k++)
         s = node_link[s];
      return s;
   endfunction

   // new node: recycled slots first, then slots never handed out
   function automatic void link_in(input int unsigned pos, input logic signed [ITEM_BITS-1:0] item);
      bit [SLOT_BITS-1:0] s, prev;
      if (spare_count != 0) begin
         s = spare_head;
         spare_head = node_link[s];
         spare_count--;
      end else begin
         s = fresh_next[SLOT_BITS-1:0];
         fresh_next++;
      end
      node_value[s] = VALUE_BITS'($unsigned(item));
      if (length_now == 0) begin
         head_at = s;
         tail_at = s;
      end else if (pos == 0) begin
         node_link[s] = head_at;
         head_at = s;
      end else if (pos >= length_now) begin
         node_link[tail_at] = s;
         tail_at = s;
      end else begin
         prev = slot_of(pos - 1);
         node_link[s] = node_link[prev];
         node_link[prev] = s;
      end
      length_now++;
   endfunction

   // drop a node and push its slot onto the recycle chain
   function automatic void unlink(input int unsigned pos);
      bit [SLOT_BITS-1:0] victim, prev;
      if (pos == 0) begin
         victim = head_at;
         head_at = node_link[victim];
      end else begin
         prev = slot_of(pos - 1);
         victim = node_link[prev];
         node_link[prev] = node_link[victim];
         if (pos + 1 == length_now)
            tail_at = prev;
      end
      node_link[victim] = spare_head;
      spare_head = victim;
      spare_count++;
      length_now--;
   endfunction

   // apply one request to the shadow list and return the response it owes
   function automatic list_answer_type predict_answer(input logic [MODE_BITS-1:0] op,
                                                      input logic [POS_BITS-1:0] pos,
                                                      input logic signed [ITEM_BITS-1:0] item);
      list_answer_type answer;
      bit              full;
      answer.status     = STATUS_DONE;
      answer.read_value = '0;
      full = (length_now >= CAPACITY);
      case (op)
         MODE_READ: begin
            if (pos >= length_now)
               answer.status = STATUS_BAD_POS;
            else
               answer.read_value = ITEM_BITS'($signed(node_value[slot_of(pos)]));
         end
         MODE_HEAD: begin
            if (full) answer.status = STATUS_FULL;
            else link_in(0, item);
         end
         MODE_TAIL: begin
            if (full) answer.status = STATUS_FULL;
            else link_in(length_now, item);
         end
         MODE_BEFORE: begin
            // position check wins over the full check
            if (pos > length_now) answer.status = STATUS_BAD_POS;
            else if (full) answer.status = STATUS_FULL;
            else link_in(pos, item);
         end
         MODE_DELETE: begin
            if (pos >= length_now) answer.status = STATUS_BAD_POS;
            else unlink(pos);
         end
         default: answer.status = STATUS_BAD_POS;
      endcase
      answer.length = LENGTH_BITS'(length_now);
      return answer;
   endfunction

   // present one request, hold it until the block takes it, then log what it owes;
   // start is only touched once per time step so back-to-back requests stay clean
   task automatic send_request(input logic [MODE_BITS-1:0] op, input int unsigned where,
                               input logic signed [ITEM_BITS-1:0] item);
      while (!steady_sender && $urandom_range(99) < IDLE_PERCENT) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start          <= 1'b1;
      req_mode       <= op;
      req_position   <= POS_BITS'(where);
      req_item_value <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
      answers_due.push_back(predict_answer(op, POS_BITS'(where), item));
   endtask

   // sender holds off until every outstanding response is back
   task automatic wait_for_answers();
      start <= 1'b0;
      @(posedge clock);
      while (answers_due.size() != 0) @(posedge clock);
   endtask

   // response checker: one strobe per request, compared field by field
   always @(posedge clock) begin : check_answer
      list_answer_type due;
      if (!reset && rsp_strobe) begin
         if (answers_due.size() == 0) begin
            report_error("response with no request outstanding");
         end else begin
            due = answers_due.pop_front();
            if (rsp_status !== due.status)
               report_error($sformatf("status %0d, wanted %0d", rsp_status, due.status));
            if (rsp_read_value !== due.read_value)
               report_error($sformatf("read value %h, wanted %h", rsp_read_value,
                                      due.read_value));
            if (rsp_list_length !== due.length)
               report_error($sformatf("length %0d, wanted %0d", rsp_list_length, due.length));
         end
      end
   end

   // every refusal path on an empty list, plus the undefined modes
   task automatic test_refusals_when_empty();
      send_request(MODE_READ, 0, 0);
      send_request(MODE_READ, 16'hFFFF, 0);
      send_request(MODE_DELETE, 0, 0);
      send_request(MODE_DELETE, 16'hFFFF, 0);
      send_request(MODE_BEFORE, 1, $urandom);
      send_request(MODE_BEFORE, 16'hFFFF, $urandom);
      for (int m = MODE_UNUSED_FIRST; m <= MODE_UNUSED_LAST; m++)
         send_request(MODE_BITS'(m), 0, $urandom);
   endtask

   // each edit kind with extreme values, reads across the whole list
   task automatic test_basic_edits();
      // indexed insert into the empty list, then remove the only element
      send_request(MODE_BEFORE, 0, 32'sh8000_0000);
      send_request(MODE_DELETE, 0, 0);
      send_request(MODE_HEAD, 0, 32'sh7FFF_FFFF);
      send_request(MODE_TAIL, 0, -1);
      send_request(MODE_HEAD, 0, 0);
      send_request(MODE_BEFORE, 1, 32'sh8000_0000);
      // position equal to the length appends
      send_request(MODE_BEFORE, 4, 32'sh5A5A_A5A5);
      for (int unsigned p = 0; p <= 5; p++)
         send_request(MODE_READ, p, 0);
      send_request(MODE_DELETE, 2, 0);
      // tail delete, then append to check the new tail
      send_request(MODE_DELETE, 3, 0);
      send_request(MODE_TAIL, 0, 32'sh1234_5678);
      send_request(MODE_READ, 3, 0);
      send_request(MODE_READ, 2, 0);
   endtask

   // mostly in-range traffic with random values; list kept short so walks stay cheap
   task automatic test_random_traffic(input int unsigned count);
      int unsigned          pick, grow_share, where;
      logic [MODE_BITS-1:0] op;
      for (int unsigned n = 0; n < count; n++) begin
         // long stretch with the sender never idling
         steady_sender = (n >= 120 && n < 250);
         pick = $urandom_range(99);
         grow_share = (length_now < 8) ? 45 : ((length_now > 48) ? 12 : 33);
         where = 0;
         if (pick < 6) begin
            // noise: any mode, any position
            op = MODE_BITS'($urandom_range(MODE_UNUSED_LAST));
            where = $urandom_range(16'hFFFF);
         end else if (pick < 32) begin
            op = MODE_READ;
            where = $urandom_range(length_now);
         end else if (pick < 32 + grow_share) begin
            case ($urandom_range(2))
               0: op = MODE_HEAD;
               1: op = MODE_TAIL;
               default: begin
                  op = MODE_BEFORE;
                  where = $urandom_range(length_now);
               end
            endcase
         end else begin
            op = MODE_DELETE;
            where = $urandom_range(length_now);
         end
         if (n % 97 == 96)
            wait_for_answers();
         send_request(op, where, $urandom);
      end
      steady_sender = 1'b0;
   endtask

   // grow a long list, then edit and read far down the chain
   task automatic test_long_list();
      steady_sender = 1'b1;
      while (length_now < LONG_LENGTH)
         send_request(($urandom_range(1) != 0) ? MODE_HEAD : MODE_TAIL, 0, $urandom);
      steady_sender = 1'b0;
      send_request(MODE_READ, LONG_LENGTH - 1, 0);
      send_request(MODE_READ, LONG_LENGTH, 0);
      send_request(MODE_BEFORE, LONG_LENGTH + 1, $urandom);
      send_request(MODE_DELETE, LONG_LENGTH, 0);
      send_request(MODE_DELETE, LONG_LENGTH - 1, 0);
      // freed slot gets reused by the next insert
      send_request(MODE_TAIL, 0, $urandom);
      send_request(MODE_READ, LONG_LENGTH - 1, 0);
      send_request(MODE_DELETE, LONG_LENGTH / 2, 0);
      send_request(MODE_BEFORE, LONG_LENGTH / 2, $urandom);
      send_request(MODE_READ, LONG_LENGTH / 2, 0);
      // position equal to the length appends
      send_request(MODE_BEFORE, LONG_LENGTH, $urandom);
      send_request(MODE_READ, LONG_LENGTH, 0);
      send_request(MODE_DELETE, 0, 0);
      send_request(MODE_READ, 0, 0);
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_refusals_when_empty();
      test_basic_edits();
      test_random_traffic(RANDOM_COUNT);
      test_long_list();
      wait_for_answers();
      // catch any stray strobe after the last response
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("indexed_linked_list_engine regression: pass");
      else
         $display("indexed_linked_list_engine regression: fail");
      $finish;
   end

endmodule

// ----- indexed_linked_list_engine.f -----
rtl/core/ille_pkg.sv
rtl/core/indexed_linked_list_engine.sv
bench/indexed_linked_list_engine_tb.sv
